// ----- src/interval_membership_table_assert.svh -----
// Assertion macros shared by the interval membership table modules.
`ifndef INTERVAL_MEMBERSHIP_TABLE_ASSERT_SVH
`define INTERVAL_MEMBERSHIP_TABLE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define IMT_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define IMT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define IMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/imt_pkg.sv -----
// Shared constants and controller/datapath interface types of the interval membership table.
package imt_pkg;

  localparam int IMT_MAX_RANGES = 64;
  localparam int KEY_W          = 32;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_QUERY  = 1'b1;

  localparam logic [1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [1:0] STATUS_FULL     = 2'd1;
  localparam logic [1:0] STATUS_ANSWERED = 2'd2;

  typedef struct packed {
    logic       load;
    logic       scan_step;
    logic       commit;
    logic       respond;
    logic [1:0] resp_status;
  } imt_cmd_t;

  typedef struct packed {
    logic full;
    logic scan_done;
  } imt_sts_t;

endpackage

// ----- src/imt_ctrl.sv -----
// Controller state machine that sequences table scans, inserts and responses.
module imt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_mode,
  output logic              busy,
  input  imt_pkg::imt_sts_t sts,
  output imt_pkg::imt_cmd_t cmd
);

  `include "interval_membership_table_assert.svh"

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   op_r;
  logic   op_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    cmd.load        = 1'b0;
    cmd.scan_step   = 1'b0;
    cmd.commit      = 1'b0;
    cmd.respond     = 1'b0;
    cmd.resp_status = imt_pkg::STATUS_ANSWERED;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          if ((in_mode == imt_pkg::MODE_INSERT) && sts.full) begin
            // A full table rejects the transaction without touching the tables.
            cmd.respond     = 1'b1;
            cmd.resp_status = imt_pkg::STATUS_FULL;
          end else begin
            cmd.load  = 1'b1;
            op_nxt    = in_mode;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_FINISH: begin
        cmd.respond = 1'b1;
        if (op_r == imt_pkg::MODE_INSERT) begin
          cmd.commit      = 1'b1;
          cmd.resp_status = imt_pkg::STATUS_ACCEPTED;
        end
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= imt_pkg::MODE_INSERT;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  `IMT_ASSERT_NEXT(a_scan_to_finish, (state_r == ST_SCAN) && sts.scan_done, state_r == ST_FINISH, "scan end did not lead to finish")
  `IMT_ASSERT_NEXT(a_idle_after_finish, state_r == ST_FINISH, !busy, "controller stayed busy after its response")
  `IMT_ASSERT_SAME(a_step_only_in_scan, cmd.scan_step, (state_r == ST_SCAN) && !sts.scan_done, "scan step issued outside an active scan")

endmodule

// ----- src/imt_dp.sv -----
// Datapath: start and end tables, fill counts, scan pipeline, best-match and response registers.
module imt_dp #(
  parameter int MAX_RANGES = imt_pkg::IMT_MAX_RANGES
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [imt_pkg::KEY_W-1:0] in_range_start,
  input  logic signed [imt_pkg::KEY_W-1:0] in_range_end,
  input  logic signed [imt_pkg::KEY_W-1:0] in_query_value,
  input  imt_pkg::imt_cmd_t             cmd,
  output imt_pkg::imt_sts_t             sts,
  output logic                          out_strobe,
  output logic [1:0]                    out_status,
  output logic                          out_inside_res
);

  `include "interval_membership_table_assert.svh"

  localparam int IDW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CW  = $clog2(MAX_RANGES + 1);
  localparam int KW  = imt_pkg::KEY_W;
  localparam int WW  = KW + IDW;

  // Each word holds a key above the id of the range that wrote it.
  logic [WW-1:0] start_mem [MAX_RANGES];
  logic [WW-1:0] end_mem   [MAX_RANGES];

  logic [WW-1:0] s_rdata_r;
  logic [WW-1:0] e_rdata_r;

  // An equal key is overwritten, else appended; entries below the count are valid.
  logic [CW-1:0] s_cnt_r;
  logic [CW-1:0] e_cnt_r;
  logic [CW-1:0] used_r;

  logic signed [KW-1:0] start_key_r;
  logic signed [KW-1:0] end_key_r;
  logic signed [KW-1:0] qval_r;

  logic [CW-1:0] idx_r;
  logic [CW-1:0] ev_idx_r;
  logic          rd_vld_r;

  logic                 have_lo_r;
  logic signed [KW-1:0] lo_key_r;
  logic [IDW-1:0]       lo_id_r;
  logic                 have_hi_r;
  logic signed [KW-1:0] hi_key_r;
  logic [IDW-1:0]       hi_id_r;

  logic           s_hit_r;
  logic [IDW-1:0] s_hit_idx_r;
  logic           e_hit_r;
  logic [IDW-1:0] e_hit_idx_r;

  logic                 out_strobe_r;
  logic [1:0]           out_status_r;
  logic                 out_inside_r;

  logic signed [KW-1:0] s_key;
  logic signed [KW-1:0] e_key;
  logic [IDW-1:0]       s_id;
  logic [IDW-1:0]       e_id;
  logic                 s_ent_vld;
  logic                 e_ent_vld;
  logic                 lo_upd;
  logic                 hi_upd;
  logic                 s_match;
  logic                 e_match;
  logic [IDW-1:0]       s_wr_addr;
  logic [IDW-1:0]       e_wr_addr;
  logic                 inside_now;

  assign s_key = $signed(s_rdata_r[WW-1:IDW]);
  assign e_key = $signed(e_rdata_r[WW-1:IDW]);
  assign s_id  = s_rdata_r[IDW-1:0];
  assign e_id  = e_rdata_r[IDW-1:0];

  assign s_ent_vld = rd_vld_r && (ev_idx_r < s_cnt_r);
  assign e_ent_vld = rd_vld_r && (ev_idx_r < e_cnt_r);

  assign lo_upd  = s_ent_vld && (s_key <= qval_r) && (!have_lo_r || (s_key > lo_key_r));
  assign hi_upd  = e_ent_vld && (e_key >= qval_r) && (!have_hi_r || (e_key < hi_key_r));
  assign s_match = s_ent_vld && (s_key == start_key_r);
  assign e_match = e_ent_vld && (e_key == end_key_r);

  assign s_wr_addr = s_hit_r ? s_hit_idx_r : s_cnt_r[IDW-1:0];
  assign e_wr_addr = e_hit_r ? e_hit_idx_r : e_cnt_r[IDW-1:0];

  assign inside_now = have_lo_r && have_hi_r && (lo_id_r == hi_id_r);

  assign sts.full      = (used_r == CW'(MAX_RANGES));
  assign sts.scan_done = (idx_r == used_r);

  assign out_strobe     = out_strobe_r;
  assign out_status     = out_status_r;
  assign out_inside_res = out_inside_r;

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      s_rdata_r <= start_mem[idx_r[IDW-1:0]];
      e_rdata_r <= end_mem[idx_r[IDW-1:0]];
    end
    if (cmd.commit) begin
      start_mem[s_wr_addr] <= {start_key_r, used_r[IDW-1:0]};
      end_mem[e_wr_addr]   <= {end_key_r, used_r[IDW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      start_key_r <= in_range_start;
      end_key_r   <= in_range_end;
      qval_r      <= in_query_value;
    end
    if (cmd.scan_step) begin
      ev_idx_r <= idx_r;
    end
    if (lo_upd) begin
      lo_key_r <= s_key;
      lo_id_r  <= s_id;
    end
    if (hi_upd) begin
      hi_key_r <= e_key;
      hi_id_r  <= e_id;
    end
    if (s_match) begin
      s_hit_idx_r <= ev_idx_r[IDW-1:0];
    end
    if (e_match) begin
      e_hit_idx_r <= ev_idx_r[IDW-1:0];
    end
    if (cmd.respond) begin
      out_status_r <= cmd.resp_status;
      out_inside_r <= (cmd.resp_status == imt_pkg::STATUS_ANSWERED) && inside_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_cnt_r      <= '0;
      e_cnt_r      <= '0;
      used_r       <= '0;
      idx_r        <= '0;
      rd_vld_r     <= 1'b0;
      have_lo_r    <= 1'b0;
      have_hi_r    <= 1'b0;
      s_hit_r      <= 1'b0;
      e_hit_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      rd_vld_r     <= cmd.scan_step;
      out_strobe_r <= cmd.respond;
      if (cmd.load) begin
        idx_r     <= '0;
        have_lo_r <= 1'b0;
        have_hi_r <= 1'b0;
        s_hit_r   <= 1'b0;
        e_hit_r   <= 1'b0;
      end else begin
        if (cmd.scan_step) begin
          idx_r <= idx_r + CW'(1);
        end
        if (lo_upd) begin
          have_lo_r <= 1'b1;
        end
        if (hi_upd) begin
          have_hi_r <= 1'b1;
        end
        if (s_match) begin
          s_hit_r <= 1'b1;
        end
        if (e_match) begin
          e_hit_r <= 1'b1;
        end
      end
      if (cmd.commit) begin
        used_r <= used_r + CW'(1);
        if (!s_hit_r) begin
          s_cnt_r <= s_cnt_r + CW'(1);
        end
        if (!e_hit_r) begin
          e_cnt_r <= e_cnt_r + CW'(1);
        end
      end
    end
  end

  `IMT_ASSERT_ALWAYS(a_counts_bounded, (s_cnt_r <= used_r) && (e_cnt_r <= used_r), "table fill count ran ahead of the range count")
  `IMT_ASSERT_ALWAYS(a_used_bounded, used_r <= CW'(MAX_RANGES), "range count passed the table depth")
  `IMT_ASSERT_SAME(a_commit_not_full, cmd.commit, !sts.full, "insert committed into a full table")

endmodule

// ----- src/interval_membership_table.sv -----
// Interval membership table: one transaction per start, result strobed once, cannot be stalled.
// Acceptance loads the operands, the scan then reads the n ranges stored so far, and the finish
// state registers the strobe; a rejected insert into a full table strobes in the next cycle.
// No new start is taken until the scan of both tables, one entry per cycle per read port, and the response are done.
// Reset empties both tables at once through their fill counts; no clearing pass is run.
module interval_membership_table #(
  parameter int MAX_RANGES = imt_pkg::IMT_MAX_RANGES
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_mode,
  input  logic signed [imt_pkg::KEY_W-1:0] in_range_start,
  input  logic signed [imt_pkg::KEY_W-1:0] in_range_end,
  input  logic signed [imt_pkg::KEY_W-1:0] in_query_value,
  output logic                             out_strobe,
  output logic [1:0]                       out_status,
  output logic                             out_inside_res
);

  imt_pkg::imt_cmd_t cmd;
  imt_pkg::imt_sts_t sts;

  imt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .busy    (busy),
    .sts     (sts),
    .cmd     (cmd)
  );

  imt_dp #(
    .MAX_RANGES (MAX_RANGES)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_range_start (in_range_start),
    .in_range_end   (in_range_end),
    .in_query_value (in_query_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_strobe     (out_strobe),
    .out_status     (out_status),
    .out_inside_res (out_inside_res)
  );

endmodule
